// ----- rtl/ladder_logic_scan_engine_unit_defines.svh -----
// Assertion macros shared by the checker of the ladder scan engine.
`ifndef LADDER_LOGIC_SCAN_ENGINE_UNIT_DEFINES_SVH
`define LADDER_LOGIC_SCAN_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, muted while reset is asserted.
`define LLSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lles: implication check failed");

// Next-cycle implication, muted while reset is asserted.
`define LLSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lles: next-cycle check failed");

// Next-cycle implication that also covers reset itself.
`define LLSE_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lles: reset check failed");

`endif

// ----- rtl/lles_pkg.sv -----
// Types, codes and default sizes of the ladder scan engine.
`default_nettype none
package lles_pkg;

  localparam int RUNG_MAX_DEF      = 32;
  localparam int COLUMNS_DEF       = 12;
  localparam int MARKER_COUNT_DEF  = 1024;
  localparam int TIMER_COUNT_DEF   = 64;
  localparam int COUNTER_COUNT_DEF = 64;
  localparam int IO_POINTS_DEF     = 16;

  localparam int          LINK_BITS = 32;
  localparam int          Q_DEPTH   = 2;
  localparam logic [15:0] CNT_MAX   = 16'hFFFF;

  typedef enum logic [3:0] {
    OP_WR_IN = 4'd0,
    OP_READ  = 4'd1,
    OP_SCAN  = 4'd2,
    OP_EMPTY = 4'd3,
    OP_HLINE = 4'd4,
    OP_XIC   = 4'd5,
    OP_XIO   = 4'd6,
    OP_OTE   = 4'd7,
    OP_SET   = 4'd8,
    OP_RST   = 4'd9,
    OP_TON   = 4'd10,
    OP_CTU   = 4'd11,
    OP_RES   = 4'd12,
    OP_END   = 4'd13
  } op_e;

  typedef enum logic [2:0] {
    KIND_X = 3'd0,
    KIND_Y = 3'd1,
    KIND_M = 3'd2,
    KIND_T = 3'd3,
    KIND_C = 3'd4
  } kind_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [2:0]  device_kind;
    logic [9:0]  device_index;
    logic [4:0]  rung_index;
    logic [3:0]  column;
    logic        first_in_rung;
    logic [31:0] source_rung_mask;
    logic [15:0] preset;
    logic        input_value;
  } in_item_t;

  typedef struct packed {
    logic power_out;
    logic cell_active;
    logic read_value;
    logic ignored;
  } out_item_t;

  // Classified cell as handed from the front to the back.
  typedef struct packed {
    in_item_t item;
    logic     io_ok;
    logic     hit_x;
    logic     hit_y;
    logic     hit_m;
    logic     hit_t;
    logic     hit_c;
    logic     link_ok;
  } cmd_t;

  typedef struct packed {
    logic [15:0] count;
    logic        running;
    logic        finished;
  } tmr_rec_t;

  typedef struct packed {
    logic [15:0] count;
    logic        finished;
    logic        prev;
  } ctr_rec_t;

endpackage
`default_nettype wire

// ----- rtl/lles_if.sv -----
// Valid/ready channel interfaces for cells in and results out.
`default_nettype none
interface lles_in_if;
  import lles_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lles_out_if;
  import lles_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/lles_front.sv -----
// Front end: accepts cell beats and classifies device and rung ranges.
`default_nettype none
module lles_front import lles_pkg::*; #(
  parameter int RUNG_MAX      = RUNG_MAX_DEF,
  parameter int COLUMNS       = COLUMNS_DEF,
  parameter int MARKER_COUNT  = MARKER_COUNT_DEF,
  parameter int TIMER_COUNT   = TIMER_COUNT_DEF,
  parameter int COUNTER_COUNT = COUNTER_COUNT_DEF,
  parameter int IO_POINTS     = IO_POINTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lles_in_if.sink    in_ch,
  input  logic       busy,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_ready
);

  logic v_r;
  cmd_t cmd_r;
  cmd_t cls;
  logic accept;

  assign in_ch.ready = !busy && (!v_r || cmd_ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_r;
  assign cmd_valid   = v_r;

  always_comb begin
    cls.item    = in_ch.data;
    cls.io_ok   = 32'(in_ch.data.device_index) < IO_POINTS;
    cls.hit_x   = (in_ch.data.device_kind == KIND_X) && cls.io_ok;
    cls.hit_y   = (in_ch.data.device_kind == KIND_Y) && cls.io_ok;
    cls.hit_m   = (in_ch.data.device_kind == KIND_M) &&
                  (32'(in_ch.data.device_index) < MARKER_COUNT);
    cls.hit_t   = (in_ch.data.device_kind == KIND_T) &&
                  (32'(in_ch.data.device_index) < TIMER_COUNT);
    cls.hit_c   = (in_ch.data.device_kind == KIND_C) &&
                  (32'(in_ch.data.device_index) < COUNTER_COUNT);
    cls.link_ok = (32'(in_ch.data.rung_index) < RUNG_MAX) &&
                  (32'(in_ch.data.column) < COLUMNS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (accept) begin
      v_r <= 1'b1;
    end else if (cmd_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cls;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lles_queue.sv -----
// Two-entry queue between the front end and the execution back end.
`default_nettype none
module lles_queue import lles_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t push_data,
  input  logic push_valid,
  output logic push_ready,
  output cmd_t pop_data,
  output logic pop_valid,
  input  logic pop
);

  cmd_t       q_r [Q_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign push_ready = cnt_r != 2'(Q_DEPTH);
  assign push       = push_valid && push_ready;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_data   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lles_back.sv -----
// Back end: device memories, rung power and cell execution.
`default_nettype none
module lles_back import lles_pkg::*; #(
  parameter int RUNG_MAX      = RUNG_MAX_DEF,
  parameter int COLUMNS       = COLUMNS_DEF,
  parameter int MARKER_COUNT  = MARKER_COUNT_DEF,
  parameter int TIMER_COUNT   = TIMER_COUNT_DEF,
  parameter int COUNTER_COUNT = COUNTER_COUNT_DEF,
  parameter int IO_POINTS     = IO_POINTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      q_data,
  input  logic      q_valid,
  output logic      q_pop,
  output logic      busy,
  lles_out_if.source out_ch
);

  localparam int MW     = (MARKER_COUNT > 1) ? $clog2(MARKER_COUNT) : 1;
  localparam int TW     = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CW     = (COUNTER_COUNT > 1) ? $clog2(COUNTER_COUNT) : 1;
  localparam int LINK_N = (RUNG_MAX < LINK_BITS) ? RUNG_MAX : LINK_BITS;

  // memories
  logic     mrk_mem [MARKER_COUNT];
  logic     mrk_rd_r;
  tmr_rec_t tmr_mem [TIMER_COUNT];
  tmr_rec_t tmr_rd_r;
  ctr_rec_t ctr_mem [COUNTER_COUNT];
  ctr_rec_t ctr_rd_r;
  logic [TIMER_COUNT-1:0]   tmr_vld_r;
  logic [COUNTER_COUNT-1:0] ctr_vld_r;

  // last write to each memory, for reads issued in that same cycle
  logic          mbp_v_r;
  logic [MW-1:0] mbp_a_r;
  logic          mbp_d_r;
  logic          tbp_v_r;
  logic [TW-1:0] tbp_a_r;
  tmr_rec_t      tbp_d_r;
  logic          cbp_v_r;
  logic [CW-1:0] cbp_a_r;
  ctr_rec_t      cbp_d_r;

  // execute stage and flop state
  logic                 s2_v_r;
  cmd_t                 s2_r;
  logic [IO_POINTS-1:0] x_r, x_nxt;
  logic [IO_POINTS-1:0] y_r, y_nxt;
  logic [COLUMNS-1:0]   rcp_r   [RUNG_MAX];
  logic [COLUMNS-1:0]   rcp_nxt [RUNG_MAX];
  logic                 rp_r, rp_nxt;
  logic                 se_r, se_nxt;
  logic                 busy_r;
  logic [MW-1:0]        clr_a_r;
  logic                 ov_r;
  out_item_t            od_r;

  logic          s2_fire;
  logic [MW-1:0] maddr, q_maddr;
  logic [TW-1:0] taddr, q_taddr;
  logic [CW-1:0] caddr, q_caddr;
  logic          m_we, m_wd;
  logic          t_we, c_we;
  tmr_rec_t      t_wd, tmr_cur;
  ctr_rec_t      c_wd, ctr_cur;
  logic          mrk_cur;
  out_item_t     res;

  assign s2_fire = s2_v_r && (!ov_r || out_ch.ready);
  assign q_pop   = q_valid && (!s2_v_r || s2_fire);
  assign busy    = busy_r;

  assign maddr   = MW'(s2_r.item.device_index);
  assign taddr   = TW'(s2_r.item.device_index);
  assign caddr   = CW'(s2_r.item.device_index);
  assign q_maddr = MW'(q_data.item.device_index);
  assign q_taddr = TW'(q_data.item.device_index);
  assign q_caddr = CW'(q_data.item.device_index);

  assign mrk_cur = (mbp_v_r && mbp_a_r == maddr) ? mbp_d_r : mrk_rd_r;
  assign tmr_cur = (tbp_v_r && tbp_a_r == taddr) ? tbp_d_r :
                   (tmr_vld_r[taddr] ? tmr_rd_r : '0);
  assign ctr_cur = (cbp_v_r && cbp_a_r == caddr) ? cbp_d_r :
                   (ctr_vld_r[caddr] ? ctr_rd_r : '0);

  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;

  always_comb begin
    logic [IO_POINTS-1:0] io_sel;
    logic [COLUMNS-1:0]   col_bit;
    logic [COLUMNS-1:0]   rcp_sh;
    logic                 dev;
    logic                 lk;
    logic                 pin;
    logic                 pout;
    logic                 active;
    logic                 is_cell;
    tmr_rec_t             t;
    ctr_rec_t             c;

    x_nxt  = x_r;
    y_nxt  = y_r;
    rp_nxt = rp_r;
    se_nxt = se_r;
    for (int r = 0; r < RUNG_MAX; r++) begin
      rcp_nxt[r] = rcp_r[r];
    end
    m_we = 1'b0;
    m_wd = 1'b0;
    t_we = 1'b0;
    t_wd = tmr_cur;
    c_we = 1'b0;
    c_wd = ctr_cur;
    res  = '0;
    pout   = 1'b0;
    active = 1'b0;
    t      = tmr_cur;
    c      = ctr_cur;

    for (int i = 0; i < IO_POINTS; i++) begin
      io_sel[i] = 32'(s2_r.item.device_index) == i;
    end
    col_bit = COLUMNS'(1) << s2_r.item.column;

    unique case (s2_r.item.device_kind)
      KIND_X:  dev = s2_r.hit_x && |(x_r & io_sel);
      KIND_Y:  dev = s2_r.hit_y && |(y_r & io_sel);
      KIND_M:  dev = s2_r.hit_m && mrk_cur;
      KIND_T:  dev = s2_r.hit_t && tmr_cur.finished;
      KIND_C:  dev = s2_r.hit_c && ctr_cur.finished;
      default: dev = 1'b0;
    endcase

    // vertical links from earlier rungs at this column
    lk = 1'b0;
    for (int r = 0; r < LINK_N; r++) begin
      rcp_sh = rcp_r[r] >> s2_r.item.column;
      if (r < 32'(s2_r.item.rung_index) && s2_r.item.source_rung_mask[r] && rcp_sh[0]) begin
        lk = 1'b1;
      end
    end
    pin = s2_r.item.first_in_rung || rp_r || (s2_r.link_ok && lk);

    is_cell = (s2_r.item.opcode >= OP_EMPTY) && (s2_r.item.opcode <= OP_END);

    if (s2_fire) begin
      if (s2_r.item.opcode == OP_WR_IN) begin
        if (s2_r.io_ok) begin
          x_nxt = s2_r.item.input_value ? (x_r | io_sel) : (x_r & ~io_sel);
        end
      end else if (s2_r.item.opcode == OP_READ) begin
        res.read_value = dev;
      end else if (s2_r.item.opcode == OP_SCAN) begin
        y_nxt  = '0;
        rp_nxt = 1'b1;
        se_nxt = 1'b0;
        for (int r = 0; r < RUNG_MAX; r++) begin
          rcp_nxt[r] = '0;
        end
      end else if (is_cell) begin
        if (se_r) begin
          res.ignored = 1'b1;
        end else if (s2_r.item.opcode == OP_END) begin
          se_nxt = 1'b1;
        end else begin
          unique case (op_e'(s2_r.item.opcode)) inside
            OP_EMPTY: begin
              pout = pin;
            end
            OP_XIC: begin
              pout   = pin && dev;
              active = pout;
            end
            OP_XIO: begin
              pout   = pin && !dev;
              active = pout;
            end
            OP_OTE, OP_SET, OP_RST: begin
              active = pin;
              if (pin) begin
                if (s2_r.hit_x) begin
                  x_nxt = (s2_r.item.opcode != OP_RST) ? (x_r | io_sel) : (x_r & ~io_sel);
                end else if (s2_r.hit_y) begin
                  y_nxt = (s2_r.item.opcode != OP_RST) ? (y_r | io_sel) : (y_r & ~io_sel);
                end else if (s2_r.hit_m) begin
                  m_we = 1'b1;
                  m_wd = s2_r.item.opcode != OP_RST;
                end
              end
            end
            OP_TON: begin
              active = pin;
              if (s2_r.hit_t) begin
                if (pin) begin
                  if (!t.running) begin
                    t.running = 1'b1;
                    t.count   = '0;
                  end
                  if (!t.finished) begin
                    if (t.count != CNT_MAX) begin
                      t.count = t.count + 16'd1;
                    end
                    if (t.count >= s2_r.item.preset) begin
                      t.finished = 1'b1;
                    end
                  end
                end else begin
                  t = '0;
                end
                t_we = 1'b1;
                t_wd = t;
              end
            end
            OP_CTU: begin
              active = pin;
              if (s2_r.hit_c) begin
                if (pin && !c.prev && !c.finished) begin
                  if (c.count != CNT_MAX) begin
                    c.count = c.count + 16'd1;
                  end
                  if (c.count >= s2_r.item.preset) begin
                    c.finished = 1'b1;
                  end
                end
                c.prev = pin;
                c_we   = 1'b1;
                c_wd   = c;
              end
            end
            OP_RES: begin
              active = pin;
              if (pin && s2_r.hit_t) begin
                t_we = 1'b1;
                t_wd = '0;
              end else if (pin && s2_r.hit_c) begin
                c_we = 1'b1;
                c_wd = '0;
              end
            end
            default: begin
              pout   = pin;
              active = pin;
            end
          endcase
          rp_nxt = pout;
          if (s2_r.link_ok) begin
            for (int r = 0; r < RUNG_MAX; r++) begin
              if (32'(s2_r.item.rung_index) == r) begin
                rcp_nxt[r] = pout ? (rcp_r[r] | col_bit) : (rcp_r[r] & ~col_bit);
              end
            end
          end
          res.power_out   = pout;
          res.cell_active = active;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r    <= 1'b0;
      ov_r      <= 1'b0;
      x_r       <= '0;
      y_r       <= '0;
      rp_r      <= 1'b1;
      se_r      <= 1'b0;
      tmr_vld_r <= '0;
      ctr_vld_r <= '0;
      mbp_v_r   <= 1'b0;
      tbp_v_r   <= 1'b0;
      cbp_v_r   <= 1'b0;
      busy_r    <= 1'b1;
      clr_a_r   <= '0;
      for (int r = 0; r < RUNG_MAX; r++) begin
        rcp_r[r] <= '0;
      end
    end else begin
      if (q_pop) begin
        s2_v_r <= 1'b1;
      end else if (s2_fire) begin
        s2_v_r <= 1'b0;
      end
      if (s2_fire) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      rp_r <= rp_nxt;
      se_r <= se_nxt;
      for (int r = 0; r < RUNG_MAX; r++) begin
        rcp_r[r] <= rcp_nxt[r];
      end
      if (t_we) begin
        tmr_vld_r[taddr] <= 1'b1;
        tbp_v_r          <= 1'b1;
      end
      if (c_we) begin
        ctr_vld_r[caddr] <= 1'b1;
        cbp_v_r          <= 1'b1;
      end
      if (m_we) begin
        mbp_v_r <= 1'b1;
      end
      // sweep the marker memory once after reset
      if (busy_r) begin
        clr_a_r <= clr_a_r + MW'(1);
        if (clr_a_r == MW'(MARKER_COUNT - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_r <= q_data;
    end
    if (s2_fire) begin
      od_r <= res;
    end
    if (m_we) begin
      mbp_a_r <= maddr;
      mbp_d_r <= m_wd;
    end
    if (t_we) begin
      tbp_a_r <= taddr;
      tbp_d_r <= t_wd;
    end
    if (c_we) begin
      cbp_a_r <= caddr;
      cbp_d_r <= c_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mrk_mem[clr_a_r] <= 1'b0;
    end else if (m_we) begin
      mrk_mem[maddr] <= m_wd;
    end
    if (q_pop) begin
      mrk_rd_r <= mrk_mem[q_maddr];
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmr_mem[taddr] <= t_wd;
    end
    if (q_pop) begin
      tmr_rd_r <= tmr_mem[q_taddr];
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      ctr_mem[caddr] <= c_wd;
    end
    if (q_pop) begin
      ctr_rd_r <= ctr_mem[q_caddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ladder_logic_scan_engine_unit.sv -----
// Path: front register, queue entry, execute register, output register, then the result beat.
// Throughput: one cell per cycle while out_ch.ready is high and no marker clearing pass runs.
// Reset: synchronous, active low; clears I/O bits, rung power, timer and counter
// valid bits. A marker clearing pass then clears all MARKER_COUNT markers (1024 by
// default), during which in_ch.ready stays low.
// Top level: front end, two-entry queue, execution back end.
`default_nettype none
module ladder_logic_scan_engine_unit import lles_pkg::*; #(
  parameter int RUNG_MAX      = RUNG_MAX_DEF,
  parameter int COLUMNS       = COLUMNS_DEF,
  parameter int MARKER_COUNT  = MARKER_COUNT_DEF,
  parameter int TIMER_COUNT   = TIMER_COUNT_DEF,
  parameter int COUNTER_COUNT = COUNTER_COUNT_DEF,
  parameter int IO_POINTS     = IO_POINTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lles_in_if.sink    in_ch,
  lles_out_if.source out_ch
);

  // front to queue
  cmd_t fq_data;
  logic fq_valid;
  logic fq_ready;
  // queue to back
  cmd_t qb_data;
  logic qb_valid;
  logic qb_pop;
  // back reports the marker clearing pass
  logic busy;

  // Accept and classify each cell beat: device range per kind, and whether
  // the rung and column take part in vertical links.
  lles_front #(
    .RUNG_MAX      (RUNG_MAX),
    .COLUMNS       (COLUMNS),
    .MARKER_COUNT  (MARKER_COUNT),
    .TIMER_COUNT   (TIMER_COUNT),
    .COUNTER_COUNT (COUNTER_COUNT),
    .IO_POINTS     (IO_POINTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .busy      (busy),
    .cmd       (fq_data),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready)
  );

  // Decouple the two sides so a stalled result does not stall acceptance at once.
  lles_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (fq_data),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .pop_data   (qb_data),
    .pop_valid  (qb_valid),
    .pop        (qb_pop)
  );

  // Issue memory reads on pop, execute the cell from the execute register with a bypass of
  // the last write, and hold the result in the output register.
  lles_back #(
    .RUNG_MAX      (RUNG_MAX),
    .COLUMNS       (COLUMNS),
    .MARKER_COUNT  (MARKER_COUNT),
    .TIMER_COUNT   (TIMER_COUNT),
    .COUNTER_COUNT (COUNTER_COUNT),
    .IO_POINTS     (IO_POINTS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (qb_data),
    .q_valid (qb_valid),
    .q_pop   (qb_pop),
    .busy    (busy),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ----- rtl/lles_checker.sv -----
// Port-level checks of the ladder scan engine and their bind.
`default_nettype none
`include "ladder_logic_scan_engine_unit_defines.svh"
module lles_checker import lles_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  `LLSE_ASSERT_RST(a_rst_out_quiet, !rst_n, !out_valid)
  `LLSE_ASSERT_RST(a_rst_clear_hold, !rst_n, !in_ready)
  `LLSE_ASSERT_IMP(a_ignored_zero, out_valid && out_item.ignored, !out_item.power_out && !out_item.cell_active && !out_item.read_value)
  `LLSE_ASSERT_IMP(a_read_alone, out_valid && out_item.read_value, !out_item.power_out && !out_item.cell_active && !out_item.ignored)
  `LLSE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

endmodule

bind ladder_logic_scan_engine_unit lles_checker u_lles_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.data)
);
`default_nettype wire

// ----- tb/ladder_logic_scan_engine_unit_test.sv -----
// Self-checking testbench for the ladder scan engine: cells in, one result beat per cell.
`default_nettype none
module ladder_logic_scan_engine_unit_test;
  import lles_pkg::*;

  localparam int IDLE_LIMIT = 6000;  // covers the marker clearing pass after reset

  logic clk;
  logic rst_n;

  lles_in_if  in_ch ();
  lles_out_if out_ch ();

  ladder_logic_scan_engine_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Engine image kept by the testbench, same sizes as the block defaults.
  logic [IO_POINTS_DEF-1:0]    x_bits;
  logic [IO_POINTS_DEF-1:0]    y_bits;
  logic [MARKER_COUNT_DEF-1:0] m_bits;
  logic [15:0]                 tmr_cnt [TIMER_COUNT_DEF];
  logic [TIMER_COUNT_DEF-1:0]  tmr_run;
  logic [TIMER_COUNT_DEF-1:0]  tmr_done;
  logic [15:0]                 ctr_cnt [COUNTER_COUNT_DEF];
  logic [COUNTER_COUNT_DEF-1:0] ctr_done;
  logic [COUNTER_COUNT_DEF-1:0] ctr_prev;
  logic [COLUMNS_DEF-1:0]      col_power [RUNG_MAX_DEF];
  logic                        rail_power;
  logic                        scan_done;

  out_item_t expected_results[$];
  int        fail_count;
  int        idle_cycles;
  bit        calm;          // when set, neither side draws random idle gaps
  int        hold_request;  // one long receiver hold-off, in cycles

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Device bit as seen by contacts and the read op: done flags for T and C.
  function automatic logic device_bit(logic [2:0] kind, logic [9:0] idx);
    case (kind)
      KIND_X: return idx < IO_POINTS_DEF ? x_bits[idx] : 1'b0;
      KIND_Y: return idx < IO_POINTS_DEF ? y_bits[idx] : 1'b0;
      KIND_M: return idx < MARKER_COUNT_DEF ? m_bits[idx] : 1'b0;
      KIND_T: return idx < TIMER_COUNT_DEF ? tmr_done[idx] : 1'b0;
      KIND_C: return idx < COUNTER_COUNT_DEF ? ctr_done[idx] : 1'b0;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void write_coil(logic [2:0] kind, logic [9:0] idx, logic v);
    if (kind == KIND_X && idx < IO_POINTS_DEF) x_bits[idx] = v;
    else if (kind == KIND_Y && idx < IO_POINTS_DEF) y_bits[idx] = v;
    else if (kind == KIND_M && idx < MARKER_COUNT_DEF) m_bits[idx] = v;
  endfunction

  // Advance the engine image by one cell and return the result beat it yields.
  function automatic out_item_t execute_cell(in_item_t c);
    out_item_t o;
    logic      pin;
    logic      pout;
    logic      act;
    logic      in_grid;
    op_e       op;
    o = '0;
    pout = 1'b0;
    act = 1'b0;
    op = op_e'(c.opcode);
    in_grid = c.rung_index < RUNG_MAX_DEF && c.column < COLUMNS_DEF;
    if (op == OP_WR_IN) begin
      if (c.device_index < IO_POINTS_DEF) x_bits[c.device_index] = c.input_value;
      return o;
    end
    if (op == OP_READ) begin
      o.read_value = device_bit(c.device_kind, c.device_index);
      return o;
    end
    if (op == OP_SCAN) begin
      y_bits = '0;
      for (int r = 0; r < RUNG_MAX_DEF; r++) col_power[r] = '0;
      rail_power = 1'b1;
      scan_done = 1'b0;
      return o;
    end
    if (c.opcode > OP_END) return o;
    if (scan_done) begin
      o.ignored = 1'b1;
      return o;
    end
    if (op == OP_END) begin
      scan_done = 1'b1;
      return o;
    end
    // Left rail or running power, then OR in vertical links from earlier rungs.
    pin = c.first_in_rung ? 1'b1 : rail_power;
    if (in_grid)
      for (int r = 0; r < c.rung_index; r++)
        if (c.source_rung_mask[r] && col_power[r][c.column]) pin = 1'b1;
    case (op)
      OP_EMPTY: pout = pin;
      OP_XIC: begin
        pout = pin & device_bit(c.device_kind, c.device_index);
        act = pout;
      end
      OP_XIO: begin
        pout = pin & ~device_bit(c.device_kind, c.device_index);
        act = pout;
      end
      OP_OTE, OP_SET: begin
        if (pin) write_coil(c.device_kind, c.device_index, 1'b1);
        act = pin;
      end
      OP_RST: begin
        if (pin) write_coil(c.device_kind, c.device_index, 1'b0);
        act = pin;
      end
      OP_TON: begin
        if (c.device_kind == KIND_T && c.device_index < TIMER_COUNT_DEF) begin
          if (pin) begin
            if (!tmr_run[c.device_index]) begin
              tmr_run[c.device_index] = 1'b1;
              tmr_cnt[c.device_index] = '0;
            end
            if (!tmr_done[c.device_index]) begin
              if (tmr_cnt[c.device_index] != CNT_MAX)
                tmr_cnt[c.device_index] = tmr_cnt[c.device_index] + 16'd1;
              if (tmr_cnt[c.device_index] >= c.preset) tmr_done[c.device_index] = 1'b1;
            end
          end else begin
            tmr_run[c.device_index] = 1'b0;
            tmr_cnt[c.device_index] = '0;
            tmr_done[c.device_index] = 1'b0;
          end
        end
        act = pin;
      end
      OP_CTU: begin
        if (c.device_kind == KIND_C && c.device_index < COUNTER_COUNT_DEF) begin
          if (pin && !ctr_prev[c.device_index] && !ctr_done[c.device_index]) begin
            if (ctr_cnt[c.device_index] != CNT_MAX)
              ctr_cnt[c.device_index] = ctr_cnt[c.device_index] + 16'd1;
            if (ctr_cnt[c.device_index] >= c.preset) ctr_done[c.device_index] = 1'b1;
          end
          ctr_prev[c.device_index] = pin;
        end
        act = pin;
      end
      OP_RES: begin
        if (pin) begin
          if (c.device_kind == KIND_T && c.device_index < TIMER_COUNT_DEF) begin
            tmr_cnt[c.device_index] = '0;
            tmr_done[c.device_index] = 1'b0;
            tmr_run[c.device_index] = 1'b0;
          end else if (c.device_kind == KIND_C && c.device_index < COUNTER_COUNT_DEF) begin
            ctr_cnt[c.device_index] = '0;
            ctr_done[c.device_index] = 1'b0;
            ctr_prev[c.device_index] = 1'b0;
          end
        end
        act = pin;
      end
      default: begin  // hline
        pout = pin;
        act = pin;
      end
    endcase
    rail_power = pout;
    if (in_grid) col_power[c.rung_index][c.column] = pout;
    o.power_out = pout;
    o.cell_active = act;
    return o;
  endfunction

  function automatic in_item_t make_cell(op_e op, kind_e kind, int idx, int rung, int col,
                                         bit first, logic [31:0] mask, int preset, bit ival);
    in_item_t c;
    c.opcode = op;
    c.device_kind = kind;
    c.device_index = idx[9:0];
    c.rung_index = rung[4:0];
    c.column = col[3:0];
    c.first_in_rung = first;
    c.source_rung_mask = mask;
    c.preset = preset[15:0];
    c.input_value = ival;
    return c;
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0);
  endfunction

  // Drive one cell beat; entered and left at a falling edge, valid left high.
  task automatic send_cell(in_item_t c);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(execute_cell(c));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Result side: stall at random, then check each beat against the oldest expectation.
  initial begin : result_checker
    int        gap;
    out_item_t got;
    out_item_t want;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap() + hold_request;
      hold_request = 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got = out_ch.data;
      if (expected_results.size() == 0) begin
        $error("result beat with no cell waiting: %p", got);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.power_out !== want.power_out) begin
          $error("power_out: expected %0b, got %0b", want.power_out, got.power_out);
          fail_count++;
        end
        if (got.cell_active !== want.cell_active) begin
          $error("cell_active: expected %0b, got %0b", want.cell_active, got.cell_active);
          fail_count++;
        end
        if (got.read_value !== want.read_value) begin
          $error("read_value: expected %0b, got %0b", want.read_value, got.read_value);
          fail_count++;
        end
        if (got.ignored !== want.ignored) begin
          $error("ignored: expected %0b, got %0b", want.ignored, got.ignored);
          fail_count++;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL ladder_logic_scan_engine_unit");
      $finish;
    end
  end

  function automatic int draw_index(kind_e kind);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    case (kind)
      KIND_X, KIND_Y: return $urandom_range(0, IO_POINTS_DEF + 1);
      KIND_M: return $urandom_range(0, 40);
      default: return $urandom_range(0, 7);
    endcase
  endfunction

  // Random cell body aimed at a given grid place; opcode drawn from cell ops.
  function automatic in_item_t random_cell(int rung, int col, bit first);
    op_e   op;
    kind_e kind;
    int    preset;
    op = op_e'($urandom_range(OP_EMPTY, OP_RES));
    kind = kind_e'($urandom_range(0, 4));
    if (op == OP_TON && $urandom_range(0, 3) != 0) kind = KIND_T;
    if (op == OP_CTU && $urandom_range(0, 3) != 0) kind = KIND_C;
    preset = $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 4);
    return make_cell(op, kind, draw_index(kind), rung, col, first, $urandom(), preset,
                     1'($urandom_range(0, 1)));
  endfunction

  // Directed: input writes and reads of X, T and an unused kind, in range and beyond.
  task automatic test_device_access();
    send_cell(make_cell(OP_WR_IN, KIND_X, 0, 0, 0, 0, '0, 0, 1));
    send_cell(make_cell(OP_WR_IN, KIND_X, IO_POINTS_DEF - 1, 31, 15, 1, '1, 65535, 1));
    send_cell(make_cell(OP_WR_IN, KIND_X, 1023, 0, 0, 0, '0, 0, 1));
    send_cell(make_cell(OP_READ, KIND_X, IO_POINTS_DEF - 1, 0, 0, 0, '0, 0, 0));
    send_cell(make_cell(OP_READ, KIND_X, 1023, 0, 0, 0, '0, 0, 0));
    send_cell(make_cell(OP_READ, kind_e'(3'd7), 0, 0, 0, 0, '0, 0, 0));
    send_cell(make_cell(OP_READ, KIND_T, 0, 0, 0, 0, '0, 0, 0));
  endtask

  // Directed: contacts, coils, timer and counter done flags, vertical link.
  task automatic test_rung_cells();
    send_cell(make_cell(OP_SCAN, KIND_X, 0, 0, 0, 0, '0, 0, 0));
    send_cell(make_cell(OP_XIC, KIND_X, 0, 0, 0, 1, '0, 0, 0));
    send_cell(make_cell(OP_OTE, KIND_Y, 3, 0, 1, 0, '0, 0, 0));
    send_cell(make_cell(OP_XIO, KIND_X, 0, 1, 0, 1, '0, 0, 0));
    send_cell(make_cell(OP_HLINE, KIND_X, 0, 1, 1, 0, 32'h1, 0, 0));
    send_cell(make_cell(OP_TON, KIND_T, 5, 2, 0, 1, '0, 0, 0));
    send_cell(make_cell(OP_CTU, KIND_C, 63, 3, 0, 1, '0, 1, 0));
    send_cell(make_cell(OP_READ, KIND_C, 63, 0, 0, 0, '0, 0, 0));
    send_cell(make_cell(OP_SET, KIND_M, 1023, 31, 11, 1, '1, 0, 0));
    send_cell(make_cell(OP_RST, KIND_M, 1023, 31, 12, 1, '0, 0, 0));
    send_cell(make_cell(OP_RES, KIND_C, 63, 4, 0, 1, '0, 0, 0));
    send_cell(make_cell(OP_EMPTY, KIND_X, 0, 5, 11, 0, '1, 0, 0));
  endtask

  // Directed: end rung silences later cells until the next scan start.
  task automatic test_end_rung();
    send_cell(make_cell(OP_END, KIND_X, 0, 6, 0, 1, '0, 0, 0));
    send_cell(make_cell(OP_OTE, KIND_Y, 1, 6, 1, 1, '0, 0, 0));
    send_cell(make_cell(OP_READ, KIND_Y, 3, 0, 0, 0, '0, 0, 0));
    send_cell(make_cell(OP_SCAN, KIND_X, 0, 0, 0, 0, '0, 0, 0));
    send_cell(make_cell(OP_READ, KIND_Y, 3, 0, 0, 0, '0, 0, 0));
  endtask

  // Random programs, each run over several scans with fresh inputs between scans.
  task automatic test_scan_programs(int budget);
    in_item_t prog[$];
    int       sent;
    int       rungs;
    int       cols;
    sent = 0;
    while (sent < budget) begin
      prog.delete();
      rungs = $urandom_range(1, 6);
      for (int r = 0; r < rungs; r++) begin
        cols = $urandom_range(1, 5);
        for (int k = 0; k < cols; k++) prog.push_back(random_cell(r, k, k == 0));
      end
      if ($urandom_range(0, 2) == 0) begin
        prog.insert($urandom_range(0, prog.size()),
                    make_cell(OP_END, KIND_X, 0, 0, 0, 1, '0, 0, 0));
      end
      repeat ($urandom_range(2, 6)) begin
        calm = $urandom_range(0, 4) == 0;
        repeat ($urandom_range(0, 3)) begin
          send_cell(make_cell(OP_WR_IN, KIND_X, $urandom_range(0, IO_POINTS_DEF - 1), 0, 0, 0,
                              '0, 0, 1'($urandom_range(0, 1))));
          sent++;
        end
        send_cell(make_cell(OP_SCAN, KIND_X, 0, 0, 0, 0, '0, 0, 0));
        foreach (prog[i]) send_cell(prog[i]);
        sent += prog.size() + 1;
        if ($urandom_range(0, 3) == 0) begin
          send_cell(make_cell(OP_READ, kind_e'($urandom_range(0, 4)), $urandom_range(0, 20),
                              0, 0, 0, '0, 0, 0));
          sent++;
        end
      end
    end
    calm = 0;
  endtask

  // Noise: random field values, with opcodes limited to the defined ones.
  task automatic test_noise(int count);
    in_item_t    c;
    logic [95:0] raw;
    repeat (count) begin
      raw = {$urandom(), $urandom(), $urandom()};
      c = raw[$bits(in_item_t)-1:0];
      c.opcode = 4'($urandom_range(OP_WR_IN, OP_END));
      c.device_kind = 3'($urandom_range(0, 7));
      send_cell(c);
    end
  endtask

  // Backpressure: receiver holds off while cells keep coming, then a full drain.
  task automatic test_backpressure();
    calm = 1;
    hold_request = 60;
    test_noise(20);
    calm = 0;
    wait_drained();
    @(negedge clk);
  endtask

  initial begin : stimulus
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    rst_n = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    calm = 0;
    hold_request = 0;
    x_bits = '0;
    y_bits = '0;
    m_bits = '0;
    tmr_run = '0;
    tmr_done = '0;
    ctr_done = '0;
    ctr_prev = '0;
    for (int i = 0; i < TIMER_COUNT_DEF; i++) tmr_cnt[i] = '0;
    for (int i = 0; i < COUNTER_COUNT_DEF; i++) ctr_cnt[i] = '0;
    for (int r = 0; r < RUNG_MAX_DEF; r++) col_power[r] = '0;
    rail_power = 1'b1;
    scan_done = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_device_access();
    test_rung_cells();
    test_end_rung();
    test_backpressure();
    test_scan_programs(560);
    test_noise(80);
    test_scan_programs(60);

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS ladder_logic_scan_engine_unit");
    end else begin
      $display("FAIL ladder_logic_scan_engine_unit");
    end
    $finish;
  end

endmodule
`default_nettype wire
